// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/kgr_pkg.sv =====
// ----------------------------------------------------------------------------
// kgr_pkg
// Types and fixed constants shared by the group reverser modules.
// ----------------------------------------------------------------------------
package kgr_pkg;

    localparam int VALUE_W = 32;
    localparam int GSIZE_W = 5;
    // Count field wide enough for any supported group depth (up to 127).
    localparam int CNT_W   = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      list_end;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      end_of_list;
        logic                      burst_last;
    } t_out_item;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             reverse;
        logic             eol;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

// ===== rtl/core/k_group_reverser.sv =====
// ----------------------------------------------------------------------------
// k_group_reverser
// Streams a list of signed values and reverses it in groups of group_size.
// ----------------------------------------------------------------------------
// Items are written into one of two RAM banks of MAX_K entries. A group that
// fills to group_size is emitted reversed; a short group closed by list_end is
// emitted in order. The front takes one item per cycle while its bank is
// free and stalls only when both banks wait for the back. The back issues one
// RAM read per cycle on the single read port while its output buffer has space,
// so a burst of n results leaves at one per cycle while the output is ready.
// The first result passes through the group queue, the back's command register,
// the RAM read register and the output buffer.
module k_group_reverser import kgr_pkg::*; #(
    parameter int MAX_K = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [GSIZE_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int AW = $clog2(2 * MAX_K);

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [VALUE_W-1:0] rdata;
    logic               q_push;
    t_cmd               q_in_cmd;
    logic               q_pop;
    logic               q_valid;
    logic               q_full;
    t_cmd               q_out_cmd;
    t_release           release_bank;
    logic               q_overflow;
    logic               cmd_count_ok;
    logic               eol_seen;

    kgr_front #(.MAX_K(MAX_K)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_release   (release_bank),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd)
    );

    kgr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_out_cmd)
    );

    kgr_ram #(.WIDTH(VALUE_W), .DEPTH(2 * MAX_K)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    kgr_back #(.MAX_K(MAX_K)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_release   (release_bank),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    assign q_overflow   = q_push && q_full && !q_pop;
    assign cmd_count_ok = (q_in_cmd.count != '0) && (q_in_cmd.count <= CNT_W'(MAX_K));
    assign eol_seen     = o_out_valid && o_out.end_of_list;

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, q_overflow, "group queue overflow")
    `ASSERT_IMPLIES(a_cmd_count, i_clk, i_rst_n, q_push, cmd_count_ok, "closed group has bad count")
    `ASSERT_IMPLIES(a_eol_is_last, i_clk, i_rst_n, eol_seen, o_out.burst_last, "end of list early")

endmodule

// ===== rtl/core/kgr_ram.sv =====
// ----------------------------------------------------------------------------
// kgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/kgr_front.sv =====
// ----------------------------------------------------------------------------
// kgr_front
// Accepts list items, writes them into the active bank and closes groups.
// ----------------------------------------------------------------------------
module kgr_front import kgr_pkg::*; #(
    parameter int MAX_K = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  t_in_item                     i_in,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [GSIZE_W-1:0]           i_cfg_data,
    input  t_release                     i_release,
    output logic                         o_we,
    output logic [$clog2(2*MAX_K)-1:0]   o_waddr,
    output logic [VALUE_W-1:0]           o_wdata,
    output logic                         o_push,
    output t_cmd                         o_cmd
);

    localparam int AW = $clog2(2 * MAX_K);
    localparam int FW = $clog2(MAX_K + 1);

    logic [GSIZE_W-1:0] r_group_size;
    logic [FW-1:0]      r_fill, n_fill;
    logic               r_wbank, n_wbank;
    logic [1:0]         r_busy, n_busy;

    logic               accept;
    logic [CNT_W-1:0]   k_eff;
    logic [CNT_W-1:0]   n_held;
    logic               full_group;
    logic               close;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy[r_wbank];
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        if (r_group_size == '0) begin
            k_eff = CNT_W'(1);
        end else if (CNT_W'(r_group_size) > CNT_W'(MAX_K)) begin
            k_eff = CNT_W'(MAX_K);
        end else begin
            k_eff = CNT_W'(r_group_size);
        end
    end

    assign n_held     = CNT_W'(r_fill) + CNT_W'(1);
    assign full_group = (n_held >= k_eff);
    assign close      = accept && (full_group || i_in.list_end);

    assign o_we    = accept;
    assign o_waddr = (r_wbank ? AW'(MAX_K) : AW'(0)) + AW'(r_fill);
    assign o_wdata = i_in.value;

    assign o_push        = close;
    assign o_cmd.bank    = r_wbank;
    assign o_cmd.count   = n_held;
    assign o_cmd.reverse = full_group;
    assign o_cmd.eol     = i_in.list_end;

    always_comb begin
        n_fill  = r_fill;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (close) begin
            n_fill          = '0;
            n_wbank         = !r_wbank;
            n_busy[r_wbank] = 1'b1;
        end else if (accept) begin
            n_fill = FW'(n_held);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GSIZE_W'(1);
            r_fill       <= '0;
            r_wbank      <= 1'b0;
            r_busy       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_group_size <= i_cfg_data;
            end
            r_fill  <= n_fill;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

// ===== rtl/core/kgr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// kgr_cmd_queue
// Two-entry queue of closed groups between the front and the back.
// ----------------------------------------------------------------------------
module kgr_cmd_queue import kgr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd       r_e0, r_e1;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_e0;

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (i_push && r_cnt == 2'd1) begin
                r_e0 <= i_cmd;
            end else begin
                r_e0 <= r_e1;
            end
            if (i_push && r_cnt == 2'd2) begin
                r_e1 <= i_cmd;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_e0 <= i_cmd;
            end else begin
                r_e1 <= i_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/core/kgr_back.sv =====
// ----------------------------------------------------------------------------
// kgr_back
// Reads closed groups out of the RAM in the right order into a two-entry
// output buffer.
// ----------------------------------------------------------------------------
module kgr_back import kgr_pkg::*; #(
    parameter int MAX_K = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  t_cmd                       i_q_cmd,
    output logic                       o_q_pop,
    output logic [$clog2(2*MAX_K)-1:0] o_raddr,
    input  logic [VALUE_W-1:0]         i_rdata,
    output t_release                   o_release,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_item                  o_out
);

    localparam int AW = $clog2(2 * MAX_K);
    localparam int FW = $clog2(MAX_K + 1);

    logic          r_act;
    t_cmd          r_cmd;
    logic [FW-1:0] r_cnt;
    logic          r_pend;
    logic          r_tag_last;
    logic          r_tag_eol;

    t_out_item     r_b0, r_b1;
    logic [1:0]    r_occ;

    logic          pop_out;
    logic          space;
    logic          issue;
    logic          issue_last;
    logic [FW-1:0] cnt_inc;
    logic [FW-1:0] offset;
    t_out_item     new_item;

    assign pop_out = o_out_valid && i_out_ready;
    assign space   = ((r_occ + 2'(r_pend)) < 2'd2) || pop_out;
    assign issue   = r_act && space;
    assign cnt_inc = r_cnt + FW'(1);
    assign issue_last = issue && (cnt_inc == FW'(r_cmd.count));

    assign offset  = r_cmd.reverse ? (FW'(r_cmd.count) - cnt_inc) : r_cnt;
    assign o_raddr = (r_cmd.bank ? AW'(MAX_K) : AW'(0)) + AW'(offset);

    assign o_q_pop = i_q_valid && (!r_act || issue_last);

    assign o_release.valid = issue_last;
    assign o_release.bank  = r_cmd.bank;

    assign new_item.out_value   = i_rdata;
    assign new_item.end_of_list = r_tag_eol;
    assign new_item.burst_last  = r_tag_last;

    assign o_out_valid = (r_occ != 2'd0);
    assign o_out       = r_b0;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_cnt <= '0;
        end else if (issue) begin
            r_cnt <= cnt_inc;
        end
        r_tag_last <= issue_last;
        r_tag_eol  <= issue_last && r_cmd.eol;
    end

    always_ff @(posedge i_clk) begin
        if (pop_out) begin
            if (r_pend && r_occ == 2'd1) begin
                r_b0 <= new_item;
            end else begin
                r_b0 <= r_b1;
            end
            if (r_pend && r_occ == 2'd2) begin
                r_b1 <= new_item;
            end
        end else if (r_pend) begin
            if (r_occ == 2'd0) begin
                r_b0 <= new_item;
            end else begin
                r_b1 <= new_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_pend <= 1'b0;
            r_occ  <= 2'd0;
        end else begin
            if (o_q_pop) begin
                r_act <= 1'b1;
            end else if (issue_last) begin
                r_act <= 1'b0;
            end
            r_pend <= issue;
            r_occ  <= r_occ + 2'(r_pend) - 2'(pop_out);
        end
    end

endmodule

// ===== tb/k_group_reverser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_group_reverser_tb
// Streams lists of signed values through the group reverser under random
// valid/ready idling. A tracker class rebuilds every emitted group from the
// accepted elements and the current group size, and checks each result in
// order. Directed lists cover the size extremes, mid-group size changes and
// lists that close on a full or partial group. Random lists follow.
// ----------------------------------------------------------------------------
module k_group_reverser_tb;
    import kgr_pkg::*;

    localparam int GROUP_MAX     = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int STUCK_LIMIT   = 2000;
    localparam int TOTAL_ITEMS   = 170;
    localparam int MAX_REPORTS   = 10;

    class group_reversal_tracker;
        t_out_item          expected_q[$];
        logic signed [31:0] held_vals[$];
        int unsigned        held_cnt;
        logic [4:0]         size_reg;
        int unsigned        mismatches;

        function new();
            held_cnt   = 0;
            size_reg   = 5'd1;
            mismatches = 0;
        endfunction

        function void set_size(logic [4:0] s);
            size_reg = s;
        endfunction

        function int unsigned span();
            if (size_reg == 0) begin
                return 1;
            end
            if (size_reg > GROUP_MAX) begin
                return GROUP_MAX;
            end
            return size_reg;
        endfunction

        function void take_element(t_in_item it);
            int unsigned k;
            int unsigned n;
            t_out_item   r;
            k = span();
            held_vals.push_back(it.value);
            held_cnt++;
            n = held_cnt;
            if (n >= k || it.list_end) begin
                for (int unsigned i = 0; i < n; i++) begin
                    r.out_value   = (n >= k) ? held_vals[n - 1 - i] : held_vals[i];
                    r.burst_last  = (i + 1 == n);
                    r.end_of_list = it.list_end && (i + 1 == n);
                    expected_q.push_back(r);
                end
                held_vals.delete();
                held_cnt = 0;
            end
        endfunction

        function void match_output(t_out_item got);
            t_out_item exp_item;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: unexpected item value %0d eol %0b last %0b",
                             got.out_value, got.end_of_list, got.burst_last);
                end
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.out_value !== exp_item.out_value ||
                got.end_of_list !== exp_item.end_of_list ||
                got.burst_last !== exp_item.burst_last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch: expected value %0d eol %0b last %0b, got value %0d eol %0b last %0b",
                             exp_item.out_value, exp_item.end_of_list, exp_item.burst_last,
                             got.out_value, got.end_of_list, got.burst_last);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [4:0] cfg_data = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_item;
    logic       cfg_ready;

    logic       in_idle_on = 1'b1;
    logic       out_idle_on = 1'b1;
    logic       hold_req = 1'b0;
    int         hold_left = 0;
    int         stuck_cycles = 0;
    int         items_sent = 0;

    group_reversal_tracker tracker = new();

    k_group_reverser #(
        .MAX_K(GROUP_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            tracker.take_element(in_item);
        end
        if (rst_n && out_valid && out_ready) begin
            tracker.match_output(out_item);
        end
    end

    // The receiver runs its own long hold-off when the stimulus asks for one.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (out_idle_on) begin
            out_ready <= ($urandom_range(99) >= 31);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(9))
            0: begin
                return 32'sh7FFF_FFFF;
            end
            1: begin
                return 32'sh8000_0000;
            end
            2: begin
                return 32'sh0;
            end
            3: begin
                return -32'sd1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic logic [4:0] pick_size();
        case ($urandom_range(7))
            0: begin
                return 5'($urandom_range(17, 31));
            end
            1: begin
                return 5'd0;
            end
            default: begin
                return 5'($urandom_range(1, GROUP_MAX));
            end
        endcase
    endfunction

    task automatic send_element(input logic signed [31:0] v, input logic last);
        while (in_idle_on && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_item.value    <= v;
        in_item.list_end <= last;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_size(input logic [4:0] s);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        tracker.set_size(s);
    endtask

    task automatic send_list(input int len, input logic closed);
        for (int j = 0; j < len; j++) begin
            send_element(rand_value(), closed && (j == len - 1));
        end
    endtask

    initial begin
        int lists;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size of one passes elements straight through.
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b1);
        settle_outputs();

        load_size(5'd0);
        send_element(32'sh0, 1'b1);
        settle_outputs();

        // An oversized setting acts as the largest group, filled by the final list element.
        load_size(5'd31);
        for (int j = 0; j < GROUP_MAX - 1; j++) begin
            send_element(rand_value(), 1'b0);
        end
        send_element(-32'sd1, 1'b1);
        settle_outputs();

        load_size(5'd4);
        send_element(32'sd1, 1'b0);
        send_element(32'sd2, 1'b0);
        send_element(32'sd3, 1'b1);
        settle_outputs();

        // Shrinking the size while a group is held flushes all held elements.
        load_size(5'd3);
        send_element(32'sd10, 1'b0);
        send_element(32'sd20, 1'b0);
        settle_outputs();
        load_size(5'd1);
        send_element(32'sd30, 1'b1);
        settle_outputs();

        load_size(5'd16);
        in_idle_on = 1'b0;
        hold_req   = 1'b1;
        send_list(40, 1'b1);
        in_idle_on = 1'b1;
        settle_outputs();

        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        load_size(5'($urandom_range(1, GROUP_MAX)));
        send_list(30, 1'b1);
        settle_outputs();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        while (items_sent < TOTAL_ITEMS) begin
            load_size(pick_size());
            lists = $urandom_range(1, 3);
            for (int l = 0; l < lists && items_sent < TOTAL_ITEMS; l++) begin
                send_list($urandom_range(1, 24), ($urandom_range(5) != 0));
            end
            settle_outputs();
        end

        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/kgr_pkg.sv
rtl/core/kgr_ram.sv
rtl/core/kgr_front.sv
rtl/core/kgr_cmd_queue.sv
rtl/core/kgr_back.sv
rtl/core/k_group_reverser.sv
tb/k_group_reverser_tb.sv
